[src/ascii_integer_field_parser_defines.svh]
// assertion macros for the ascii integer field parser
// expects clk_i and rst_ni in the scope of each use
`ifndef ASCII_INTEGER_FIELD_PARSER_DEFINES_SVH
`define ASCII_INTEGER_FIELD_PARSER_DEFINES_SVH

// antecedent and consequent in the same cycle
`define AIFP_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// consequent in the cycle after the antecedent
`define AIFP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/aifp_pkg.sv]
// shared types and codes for the ascii integer field parser
// no dependencies
package aifp_pkg;

  localparam int unsigned ChW   = 8;
  localparam int unsigned ValW  = 64;
  localparam int unsigned CntW  = 8;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 8;

  localparam logic [2:0] MODE_SDEC = 3'd0;
  localparam logic [2:0] MODE_AUTO = 3'd1;
  localparam logic [2:0] MODE_OCT  = 3'd2;
  localparam logic [2:0] MODE_UDEC = 3'd3;
  localparam logic [2:0] MODE_HEX  = 3'd4;

  localparam logic [1:0] SIZE_16 = 2'd0;
  localparam logic [1:0] SIZE_32 = 2'd1;
  localparam logic [1:0] SIZE_64 = 2'd2;

  localparam logic [CfgIdxW-1:0] REG_CONV_MODE   = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_SIZE_MODE   = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_FIELD_WIDTH = 2'd2;

  typedef struct packed {
    logic [2:0]      conv_mode;
    logic [1:0]      size_mode;
    logic [CntW-1:0] field_width;
  } cfg_t;

  typedef struct packed {
    logic            emit;
    logic [ValW-1:0] value;
    logic            converted;
    logic            end_of_text;
  } res_t;

endpackage

[src/aifp_cfg.sv]
// configuration registers of the ascii integer field parser
// depends on aifp_pkg
module aifp_cfg (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                wr_i,
  input  logic [aifp_pkg::CfgIdxW-1:0]        index_i,
  input  logic [aifp_pkg::CfgDataW-1:0]       data_i,
  output aifp_pkg::cfg_t                      cfg_o
);

  aifp_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_i) begin
      case (index_i)
        aifp_pkg::REG_CONV_MODE:   cfg_d.conv_mode   = data_i[2:0];
        aifp_pkg::REG_SIZE_MODE:   cfg_d.size_mode   = data_i[1:0];
        aifp_pkg::REG_FIELD_WIDTH: cfg_d.field_width = data_i[aifp_pkg::CntW-1:0];
        default:                   cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.conv_mode   <= aifp_pkg::MODE_SDEC;
      cfg_q.size_mode   <= aifp_pkg::SIZE_32;
      cfg_q.field_width <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[src/aifp_core.sv]
// field state and per-beat conversion logic of the ascii integer field parser
// depends on aifp_pkg and ascii_integer_field_parser_defines.svh
`include "ascii_integer_field_parser_defines.svh"

module aifp_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        fire_i,
  input  logic [aifp_pkg::ChW-1:0]    ch_i,
  input  logic                        last_i,
  input  aifp_pkg::cfg_t              cfg_i,
  output aifp_pkg::res_t              res_o
);

  typedef enum logic [4:0] {
    PH_SKIP   = 5'b00001,
    PH_SIGN   = 5'b00010,
    PH_ZERO   = 5'b00100,
    PH_X      = 5'b01000,
    PH_DIGITS = 5'b10000
  } phase_e;

  typedef enum logic [1:0] {
    RADIX_8,
    RADIX_10,
    RADIX_16
  } radix_e;

  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChSeven = 8'h37;
  localparam logic [7:0] ChLowA  = 8'h61;
  localparam logic [7:0] ChLowF  = 8'h66;
  localparam logic [7:0] ChUpA   = 8'h41;
  localparam logic [7:0] ChUpF   = 8'h46;
  localparam logic [7:0] ChLowX  = 8'h78;
  localparam logic [7:0] ChUpX   = 8'h58;
  localparam logic [7:0] ChMinus = 8'h2d;
  localparam logic [7:0] ChPlus  = 8'h2b;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChCr    = 8'h0d;

  localparam int unsigned VW = aifp_pkg::ValW;
  localparam int unsigned CW = aifp_pkg::CntW;

  phase_e          phase_q, phase_d, e_phase, ph;
  radix_e          radix_q, radix_d, e_radix;
  logic            neg_q, neg_d, e_neg;
  logic [VW-1:0]   acc_q, acc_d, e_acc, prod, sdig;
  logic            seen_q, seen_d, e_seen;
  logic [CW-1:0]   fc_q, fc_d, e_fc;
  logic            stop_q, stop_d, e_stop;
  logic [2:0]      mode;
  logic            ws, done, dig_ok, sgn_mode;
  logic [3:0]      dig_val;
  aifp_pkg::res_t  res;

  function automatic logic [VW-1:0] extend(input logic [VW-1:0] v, input logic [1:0] size,
                                           input logic sgn);
    logic [VW-1:0] r;
    case (size)
      aifp_pkg::SIZE_16: r = {{(VW-16){sgn & v[15]}}, v[15:0]};
      aifp_pkg::SIZE_32: r = {{(VW-32){sgn & v[31]}}, v[31:0]};
      default:           r = v;
    endcase
    return r;
  endfunction

  always_comb begin
    mode     = (cfg_i.conv_mode > aifp_pkg::MODE_HEX) ? aifp_pkg::MODE_HEX : cfg_i.conv_mode;
    sgn_mode = (mode == aifp_pkg::MODE_SDEC) || (mode == aifp_pkg::MODE_AUTO);
    ws       = (ch_i == ChSpace) || ((ch_i >= ChTab) && (ch_i <= ChCr));

    // digit decode against the radix in force
    dig_ok  = 1'b0;
    dig_val = ch_i[3:0];
    e_radix = (phase_q == PH_SKIP) ?
              ((mode == aifp_pkg::MODE_OCT) ? RADIX_8 :
               (mode == aifp_pkg::MODE_HEX) ? RADIX_16 : RADIX_10) : radix_q;
    if ((ch_i >= ChZero) && (ch_i <= ChNine)) begin
      dig_ok = (e_radix != RADIX_8) || (ch_i <= ChSeven);
    end else if (e_radix == RADIX_16) begin
      if (((ch_i >= ChLowA) && (ch_i <= ChLowF)) || ((ch_i >= ChUpA) && (ch_i <= ChUpF))) begin
        dig_ok  = 1'b1;
        dig_val = ch_i[3:0] + 4'd9;
      end
    end

    if (phase_q == PH_SKIP) begin
      e_phase = PH_SIGN;
      e_neg   = 1'b0;
      e_acc   = '0;
      e_seen  = 1'b0;
      e_fc    = '0;
      e_stop  = 1'b0;
    end else begin
      e_phase = phase_q;
      e_neg   = neg_q;
      e_acc   = acc_q;
      e_seen  = seen_q;
      e_fc    = fc_q;
      e_stop  = stop_q;
    end

    // accumulator kept with its sign applied, so a negative field subtracts digits
    case (e_radix)
      RADIX_8:  prod = {e_acc[VW-4:0], 3'b000};
      RADIX_16: prod = {e_acc[VW-5:0], 4'b0000};
      default:  prod = {e_acc[VW-4:0], 3'b000} + {e_acc[VW-2:0], 1'b0};
    endcase
    sdig = e_neg ? ({VW{1'b0}} - {{(VW-4){1'b0}}, dig_val}) : {{(VW-4){1'b0}}, dig_val};

    phase_d = phase_q;
    radix_d = radix_q;
    neg_d   = neg_q;
    acc_d   = acc_q;
    seen_d  = seen_q;
    fc_d    = fc_q;
    stop_d  = stop_q;
    ph      = e_phase;
    done    = 1'b0;
    res     = '0;

    if (ws) begin
      if (phase_q != PH_SKIP) begin
        res.emit        = 1'b1;
        res.value       = seen_q ? extend(acc_q, cfg_i.size_mode, sgn_mode) : '0;
        res.converted   = seen_q;
        res.end_of_text = last_i;
      end
    end else begin
      phase_d = e_phase;
      radix_d = e_radix;
      neg_d   = e_neg;
      acc_d   = e_acc;
      seen_d  = e_seen;
      stop_d  = e_stop;
      fc_d    = (e_fc == {CW{1'b1}}) ? e_fc : e_fc + 1'b1;
      if (!e_stop) begin
        if (ph == PH_SIGN) begin
          if (sgn_mode && ((ch_i == ChMinus) || (ch_i == ChPlus))) begin
            neg_d   = (ch_i == ChMinus);
            phase_d = PH_ZERO;
            done    = 1'b1;
          end else begin
            ph = PH_ZERO;
          end
        end
        if (!done && (ph == PH_ZERO)) begin
          if (((mode == aifp_pkg::MODE_AUTO) || (mode == aifp_pkg::MODE_HEX)) &&
              (ch_i == ChZero)) begin
            seen_d  = 1'b1;
            radix_d = (mode == aifp_pkg::MODE_AUTO) ? RADIX_8 : e_radix;
            phase_d = PH_X;
            done    = 1'b1;
          end else begin
            ph = PH_DIGITS;
          end
        end
        if (!done && (ph == PH_X)) begin
          if ((ch_i == ChLowX) || (ch_i == ChUpX)) begin
            radix_d = RADIX_16;
            phase_d = PH_DIGITS;
            done    = 1'b1;
          end
        end
        if (!done) begin
          phase_d = PH_DIGITS;
          if (dig_ok) begin
            acc_d  = prod + sdig;
            seen_d = 1'b1;
          end else begin
            stop_d = 1'b1;
          end
        end
      end
      if (last_i || ((cfg_i.field_width != '0) && (fc_d >= cfg_i.field_width))) begin
        res.emit        = 1'b1;
        res.value       = seen_d ? extend(acc_d, cfg_i.size_mode, sgn_mode) : '0;
        res.converted   = seen_d;
        res.end_of_text = last_i;
      end
    end

    if (res.emit) begin
      phase_d = PH_SKIP;
      radix_d = RADIX_10;
      neg_d   = 1'b0;
      acc_d   = '0;
      seen_d  = 1'b0;
      fc_d    = '0;
      stop_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SKIP;
      radix_q <= RADIX_10;
      neg_q   <= 1'b0;
      acc_q   <= '0;
      seen_q  <= 1'b0;
      fc_q    <= '0;
      stop_q  <= 1'b0;
    end else if (fire_i) begin
      phase_q <= phase_d;
      radix_q <= radix_d;
      neg_q   <= neg_d;
      acc_q   <= acc_d;
      seen_q  <= seen_d;
      fc_q    <= fc_d;
      stop_q  <= stop_d;
    end
  end

  assign res_o = res;

  `AIFP_ASSERT_NEXT(a_emit_clears, fire_i && res.emit, phase_q == PH_SKIP, "field not cleared after result")
  `AIFP_ASSERT_SAME(a_acc_needs_digit, !seen_q, acc_q == '0, "accumulator set without a digit")
  `AIFP_ASSERT_SAME(a_stop_in_digits, stop_q, phase_q == PH_DIGITS, "digits stopped outside digit phase")

endmodule

[src/ascii_integer_field_parser.sv]
// top level of the ascii integer field parser: input register, core, result register
// depends on aifp_pkg, aifp_cfg, aifp_core and ascii_integer_field_parser_defines.svh
//
//   channel    | dir | handshake                   | payload
//   s_axis     | in  | s_axis_tvalid/s_axis_tready | tdata = ch, tlast = last
//   m_axis     | out | m_axis_tvalid/m_axis_tready | tdata = value, tuser = converted,
//              |     |                             | tlast = end_of_text
//   cfg        | in  | cfg_valid_i/cfg_ready_o     | cfg_index_i, cfg_data_i
//
// one character per cycle while the result register is not stalled; a taken beat passes
// the input register, then the result register behind the single-pass field logic
// reset leaves the parser skipping whitespace with mode 0, 32-bit size, no width limit
// a stalled result register holds the input register, which then holds s_axis_tready low
// the config port is always ready and takes one write per cycle
`include "ascii_integer_field_parser_defines.svh"

module ascii_integer_field_parser (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [aifp_pkg::ChW-1:0]           s_axis_tdata,   // [7:0] ch
  input  logic                               s_axis_tlast,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [aifp_pkg::ValW-1:0]          m_axis_tdata,   // [63:0] value
  output logic [0:0]                         m_axis_tuser,   // [0] converted
  output logic                               m_axis_tlast,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [aifp_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [aifp_pkg::CfgDataW-1:0]      cfg_data_i
);

  aifp_pkg::cfg_t            cfg;
  aifp_pkg::res_t            res;
  logic                      in_valid_q;
  logic [aifp_pkg::ChW-1:0]  in_ch_q;
  logic                      in_last_q;
  logic                      out_valid_q;
  logic [aifp_pkg::ValW-1:0] out_value_q;
  logic                      out_conv_q;
  logic                      out_eot_q;
  logic                      proc_fire;
  logic                      in_take;

  assign cfg_ready_o   = 1'b1;
  assign proc_fire     = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || proc_fire;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  aifp_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (cfg_valid_i),
    .index_i (cfg_index_i),
    .data_i  (cfg_data_i),
    .cfg_o   (cfg)
  );

  aifp_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (proc_fire),
    .ch_i   (in_ch_q),
    .last_i (in_last_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (proc_fire) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_ch_q   <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (proc_fire && res.emit) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc_fire && res.emit) begin
      out_value_q <= res.value;
      out_conv_q  <= res.converted;
      out_eot_q   <= res.end_of_text;
    end
  end

  assign m_axis_tvalid   = out_valid_q;
  assign m_axis_tdata    = out_value_q;
  assign m_axis_tuser[0] = out_conv_q;
  assign m_axis_tlast    = out_eot_q;

  `AIFP_ASSERT_SAME(a_stall_means_full, !s_axis_tready, in_valid_q && out_valid_q && !m_axis_tready, "input stalled without a blocked result")
  `AIFP_ASSERT_SAME(a_result_from_beat, $rose(m_axis_tvalid), $past(proc_fire), "result without a processed beat")

endmodule
